// File: src/led_pkg.sv
package led_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int DIST_W      = 7;
    localparam int DIST_SAT    = 127;
    localparam int CHAR_W      = 8;
    localparam int FUNC_W      = 2;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [FUNC_W-1:0] FUNC_APPEND_REF   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND_TYPED = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE      = 2'd2;

    typedef enum logic [1:0] {
        CMD_REF,
        CMD_TYPED,
        CMD_COMPUTE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CHAR_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_link_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW,
        ST_CELL,
        ST_EMIT
    } back_state_t;

endpackage

// File: src/levenshtein_edit_distance.sv
// Levenshtein edit distance between a reference byte string and a typed
// byte string; insertion, deletion and substitution each cost one.
//
// Input channel (s_axis_*): each transfer carries a selector and a byte.
// Selector 0 appends the byte to the reference, 1 appends it to the typed
// string, 2 asks for the distance, 3 is taken and dropped. Bytes beyond
// MAX_LEN per string are dropped and mark the overflow flag.
// Result channel (m_axis_*): one transfer per distance request, holding
// the distance (saturated at 127) and the overflow flag; both strings and
// the flag then start over empty.
//
// Timing: a 4-entry command queue sits between the input side and the
// sequencer. Appends retire at one per cycle while the sequencer is idle;
// during a distance request they wait in the queue. A request is paced
// by the row sweep, which computes one table cell per cycle through the
// single read and write port of the row memory, skipped if a string is empty.
// Reset clears the lengths, the flag, the queue and the result's valid bit.
// While the receiver stalls, the result holds in its register; the queue
// keeps taking items until it fills, then s_axis_tready drops.
module levenshtein_edit_distance #(
    parameter int MAX_LEN = led_pkg::MAX_LEN_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [1:0] func, [9:2] char_byte, [15:10] zero
    input  logic [led_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [6:0] distance, [7] overflow
    output logic [led_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    led_pkg::cmd_link_t cmd_link;
    logic               cmd_ready;

    // accept and classify transfers into the command queue
    led_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cmd_out       (cmd_link),
        .cmd_ready     (cmd_ready)
    );

    // store bytes, run the row sweep, hold the result
    led_back #(.MAX_LEN(MAX_LEN)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_in        (cmd_link),
        .cmd_ready     (cmd_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// File: src/led_ram.sv
module led_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/led_front.sv
module led_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [led_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output led_pkg::cmd_link_t             cmd_out,
    input  logic                           cmd_ready
);

    localparam int PTR_W = $clog2(led_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(led_pkg::QUEUE_DEPTH + 1);

    led_pkg::cmd_t           queue_reg [led_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]        count_reg,  count_next;

    logic [led_pkg::FUNC_W-1:0] func;
    logic [led_pkg::CHAR_W-1:0] char_byte;
    logic                       accept;
    logic                       push;
    logic                       pop;
    led_pkg::cmd_t              cmd_new;

    assign func      = s_axis_tdata[led_pkg::FUNC_W-1:0];
    assign char_byte = s_axis_tdata[led_pkg::FUNC_W +: led_pkg::CHAR_W];

    assign s_axis_tready = (count_reg != CNT_W'(led_pkg::QUEUE_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;

    // classify; the unused selector is taken and dropped
    always_comb begin
        cmd_new.data = char_byte;
        push         = accept;
        unique case (func)
            led_pkg::FUNC_APPEND_REF:   cmd_new.kind = led_pkg::CMD_REF;
            led_pkg::FUNC_APPEND_TYPED: cmd_new.kind = led_pkg::CMD_TYPED;
            led_pkg::FUNC_COMPUTE:      cmd_new.kind = led_pkg::CMD_COMPUTE;
            default: begin
                cmd_new.kind = led_pkg::CMD_COMPUTE;
                push         = 1'b0;
            end
        endcase
    end

    assign cmd_out.valid = (count_reg != '0);
    assign cmd_out.cmd   = queue_reg[rd_ptr_reg];
    assign pop           = cmd_out.valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= cmd_new;
        end
    end

endmodule

// File: src/led_back.sv
module led_back #(
    parameter int MAX_LEN = led_pkg::MAX_LEN_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  led_pkg::cmd_link_t             cmd_in,
    output logic                           cmd_ready,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [led_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int CHAR_AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int WIDE_W = LEN_W + led_pkg::DIST_W;

    led_pkg::back_state_t state_reg, state_next;
    logic [LEN_W-1:0] ref_len_reg,   ref_len_next;
    logic [LEN_W-1:0] typed_len_reg, typed_len_next;
    logic             ovf_reg,       ovf_next;
    logic [LEN_W-1:0] i_reg,    i_next;
    logic [LEN_W-1:0] j_reg,    j_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic [LEN_W-1:0] diag_reg, diag_next;
    logic [LEN_W-1:0] res_reg,  res_next;
    logic             m_valid_reg, m_valid_next;
    logic [led_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    // memory controls
    logic                       ref_wr_en,   typed_wr_en;
    logic [CHAR_AW-1:0]         ref_wr_addr, typed_wr_addr;
    logic                       ref_rd_en,   typed_rd_en;
    logic [CHAR_AW-1:0]         ref_rd_addr, typed_rd_addr;
    logic [led_pkg::CHAR_W-1:0] ref_rd_data, typed_rd_data;
    logic                       dp_wr_en,    dp_rd_en;
    logic [LEN_W-1:0]           dp_wr_addr,  dp_rd_addr;
    logic [LEN_W-1:0]           dp_wr_data,  dp_rd_data;

    logic [LEN_W-1:0]           min_ab;
    logic [LEN_W-1:0]           min_abc;
    logic [LEN_W-1:0]           cell_cost;
    logic [WIDE_W-1:0]          res_wide;
    logic [led_pkg::DIST_W-1:0] dist_sat;

    led_ram #(.WIDTH(led_pkg::CHAR_W), .DEPTH(MAX_LEN)) u_ref_ram (
        .aclk    (aclk),
        .wr_en   (ref_wr_en),
        .wr_addr (ref_wr_addr),
        .wr_data (cmd_in.cmd.data),
        .rd_en   (ref_rd_en),
        .rd_addr (ref_rd_addr),
        .rd_data (ref_rd_data)
    );

    led_ram #(.WIDTH(led_pkg::CHAR_W), .DEPTH(MAX_LEN)) u_typed_ram (
        .aclk    (aclk),
        .wr_en   (typed_wr_en),
        .wr_addr (typed_wr_addr),
        .wr_data (cmd_in.cmd.data),
        .rd_en   (typed_rd_en),
        .rd_addr (typed_rd_addr),
        .rd_data (typed_rd_data)
    );

    led_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN + 1)) u_dp_ram (
        .aclk    (aclk),
        .wr_en   (dp_wr_en),
        .wr_addr (dp_wr_addr),
        .wr_data (dp_wr_data),
        .rd_en   (dp_rd_en),
        .rd_addr (dp_rd_addr),
        .rd_data (dp_rd_data)
    );

    // one cell: dp_rd_data is the cell above, left_reg the cell to the left
    always_comb begin
        min_ab    = (dp_rd_data < left_reg) ? dp_rd_data : left_reg;
        min_abc   = (min_ab < diag_reg) ? min_ab : diag_reg;
        cell_cost = (ref_rd_data == typed_rd_data) ? diag_reg : min_abc + LEN_W'(1);
    end

    assign res_wide = {{led_pkg::DIST_W{1'b0}}, res_reg};
    assign dist_sat = (res_wide > WIDE_W'(led_pkg::DIST_SAT)) ?
                      led_pkg::DIST_W'(led_pkg::DIST_SAT) : res_wide[led_pkg::DIST_W-1:0];

    assign cmd_ready     = (state_reg == led_pkg::ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_comb begin
        state_next     = state_reg;
        ref_len_next   = ref_len_reg;
        typed_len_next = typed_len_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        left_next      = left_reg;
        diag_next      = diag_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;

        ref_wr_en     = 1'b0;
        typed_wr_en   = 1'b0;
        ref_wr_addr   = ref_len_reg[CHAR_AW-1:0];
        typed_wr_addr = typed_len_reg[CHAR_AW-1:0];
        ref_rd_en     = 1'b0;
        typed_rd_en   = 1'b0;
        ref_rd_addr   = ref_len_reg[CHAR_AW-1:0];
        typed_rd_addr = j_reg[CHAR_AW-1:0];
        dp_wr_en      = 1'b0;
        dp_wr_addr    = j_reg;
        dp_wr_data    = j_reg;
        dp_rd_en      = 1'b0;
        dp_rd_addr    = j_reg + LEN_W'(1);

        unique case (state_reg)
            led_pkg::ST_IDLE: begin
                if (cmd_in.valid) begin
                    unique case (cmd_in.cmd.kind)
                        led_pkg::CMD_REF: begin
                            if (ref_len_reg < LEN_W'(MAX_LEN)) begin
                                ref_wr_en    = 1'b1;
                                ref_len_next = ref_len_reg + LEN_W'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        led_pkg::CMD_TYPED: begin
                            if (typed_len_reg < LEN_W'(MAX_LEN)) begin
                                typed_wr_en    = 1'b1;
                                typed_len_next = typed_len_reg + LEN_W'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        default: begin
                            // an empty string makes the distance the other length
                            if (ref_len_reg == '0 || typed_len_reg == '0) begin
                                res_next   = ref_len_reg | typed_len_reg;
                                state_next = led_pkg::ST_EMIT;
                            end else begin
                                j_next     = LEN_W'(1);
                                state_next = led_pkg::ST_INIT;
                            end
                        end
                    endcase
                end
            end
            led_pkg::ST_INIT: begin
                // seed row zero: dp[j] = j
                dp_wr_en = 1'b1;
                if (j_reg == typed_len_reg) begin
                    i_next     = LEN_W'(1);
                    state_next = led_pkg::ST_ROW;
                end else begin
                    j_next = j_reg + LEN_W'(1);
                end
            end
            led_pkg::ST_ROW: begin
                ref_rd_en     = 1'b1;
                ref_rd_addr   = CHAR_AW'(i_reg - LEN_W'(1));
                typed_rd_en   = 1'b1;
                typed_rd_addr = '0;
                dp_rd_en      = 1'b1;
                dp_rd_addr    = LEN_W'(1);
                j_next        = LEN_W'(1);
                left_next     = i_reg;
                diag_next     = i_reg - LEN_W'(1);
                state_next    = led_pkg::ST_CELL;
            end
            led_pkg::ST_CELL: begin
                dp_wr_en   = 1'b1;
                dp_wr_data = cell_cost;
                left_next  = cell_cost;
                diag_next  = dp_rd_data;
                if (j_reg != typed_len_reg) begin
                    // fetch the next column while this one is written back
                    typed_rd_en = 1'b1;
                    dp_rd_en    = 1'b1;
                    j_next      = j_reg + LEN_W'(1);
                end else if (i_reg != ref_len_reg) begin
                    i_next     = i_reg + LEN_W'(1);
                    state_next = led_pkg::ST_ROW;
                end else begin
                    res_next   = cell_cost;
                    state_next = led_pkg::ST_EMIT;
                end
            end
            led_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next   = 1'b1;
                    m_data_next    = {ovf_reg, dist_sat};
                    ref_len_next   = '0;
                    typed_len_next = '0;
                    ovf_next       = 1'b0;
                    state_next     = led_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = led_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= led_pkg::ST_IDLE;
            ref_len_reg   <= '0;
            typed_len_reg <= '0;
            ovf_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ref_len_reg   <= ref_len_next;
            typed_len_reg <= typed_len_next;
            ovf_reg       <= ovf_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        left_reg   <= left_next;
        diag_reg   <= diag_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

endmodule

// File: src/led_checker.sv
module led_checker #(
    parameter int MAX_LEN = led_pkg::MAX_LEN_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [led_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int BOUND = (MAX_LEN > led_pkg::DIST_SAT) ? led_pkg::DIST_SAT : MAX_LEN;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // reset drops any pending result
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // queue is empty after reset, so input is ready
    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_axis_tready)
        else $error("input not ready after reset");

    // distance never exceeds the string capacity
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[led_pkg::DIST_W-1:0] <= led_pkg::DIST_W'(BOUND))
        else $error("distance out of range");

endmodule

bind levenshtein_edit_distance led_checker #(.MAX_LEN(MAX_LEN)) u_led_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
